/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SK_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");
`define SK_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define SK_ASSERT(lbl, clk, rst_n, prop)
`define SK_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

/* sv/sk_pkg.sv */
// ----------------------------------------------------------------------------
// sk_pkg
// Types, operation codes and defaults for the sorted key table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sk_pkg;

  localparam int CAPACITY_DEF      = 64;
  localparam int PAYLOAD_WIDTH_DEF = 32;

  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_REM_FIRST = 3'd1;
  localparam logic [2:0] OP_REM_LAST  = 3'd2;
  localparam logic [2:0] OP_REM_KEY   = 3'd3;
  localparam logic [2:0] OP_READ      = 3'd4;
  localparam logic [2:0] OP_FIND      = 3'd5;

  typedef struct packed {
    logic [2:0]          func;
    logic signed [31:0]  key;
    logic [31:0]         payload;
    logic [5:0]          position;
  } in_item_t;

  typedef struct packed {
    logic                ok;
    logic signed [31:0]  key_out;
    logic [31:0]         payload_out;
    logic [5:0]          index_out;
    logic [6:0]          count;
    logic                full_res;
    logic                empty_res;
  } out_item_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

/* sv/sk_mem.sv */
// ----------------------------------------------------------------------------
// sk_mem
// Entry storage: key and payload arrays, one write and one registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sk_mem import sk_pkg::*; #(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
  input  logic                         clk,
  input  mem_ctl_t                     ctl,
  input  logic [$clog2(CAPACITY)-1:0]  raddr,
  input  logic [$clog2(CAPACITY)-1:0]  waddr,
  input  logic [31:0]                  wkey,
  input  logic [PAYLOAD_WIDTH-1:0]     wpay,
  output logic [31:0]                  rkey,
  output logic [PAYLOAD_WIDTH-1:0]     rpay
);

  logic [31:0]              key_mem [CAPACITY];
  logic [PAYLOAD_WIDTH-1:0] pay_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      key_mem[waddr] <= wkey;
      pay_mem[waddr] <= wpay;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rkey <= key_mem[raddr];
      rpay <= pay_mem[raddr];
    end
  end

endmodule

/* sv/sk_ctrl.sv */
// ----------------------------------------------------------------------------
// sk_ctrl
// Operation sequencer: reads an entry by index, or walks the entry memory one entry per cycle to search,
// shift entries up for a sorted insert or down for a removal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sk_ctrl import sk_pkg::*; #(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  in_item_t                     item,
  output logic                         idle,
  output logic                         res_valid,
  input  logic                         res_ready,
  output out_item_t                    res,
  output mem_ctl_t                     mem_ctl,
  output logic [$clog2(CAPACITY)-1:0]  raddr,
  output logic [$clog2(CAPACITY)-1:0]  waddr,
  output logic [31:0]                  wkey,
  output logic [PAYLOAD_WIDTH-1:0]     wpay,
  input  logic [31:0]                  rkey,
  input  logic [PAYLOAD_WIDTH-1:0]     rpay
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 6) ? CW : 6;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DOWN  = 6'b000010,
    S_PLACE = 6'b000100,
    S_UP    = 6'b001000,
    S_READ  = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [2:0]               op_r, op_nxt;
  logic signed [31:0]       key_r, key_nxt;
  logic [PAYLOAD_WIDTH-1:0] pay_r, pay_nxt;
  logic [AW-1:0]            ptr_r, ptr_nxt;
  logic                     found_r, found_nxt;
  logic                     ok_r, ok_nxt;
  logic signed [31:0]       kout_r, kout_nxt;
  logic [31:0]              pout_r, pout_nxt;
  logic [5:0]               iout_r, iout_nxt;

  logic [AW-1:0] last_idx;
  logic          is_full;
  logic          is_empty;
  logic          match;
  logic          at_last;

  assign last_idx = AW'(count_r - CW'(1));
  assign is_full  = (count_r == CW'(CAPACITY));
  assign is_empty = (count_r == '0);
  assign match    = (rkey == key_r);
  assign at_last  = (ptr_r == last_idx);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    pay_nxt   = pay_r;
    ptr_nxt   = ptr_r;
    found_nxt = found_r;
    ok_nxt    = ok_r;
    kout_nxt  = kout_r;
    pout_nxt  = pout_r;
    iout_nxt  = iout_r;
    mem_ctl   = '0;
    raddr     = ptr_r;
    waddr     = '0;
    wkey      = key_r;
    wpay      = pay_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = item.func;
          key_nxt   = item.key;
          pay_nxt   = PAYLOAD_WIDTH'(item.payload);
          ok_nxt    = 1'b0;
          kout_nxt  = '0;
          pout_nxt  = '0;
          iout_nxt  = '0;
          found_nxt = 1'b0;
          state_nxt = S_RESP;
          unique case (item.func)
            OP_INSERT: begin
              if (!is_full && is_empty) begin
                mem_ctl.wr_en = 1'b1;
                waddr         = '0;
                wkey          = item.key;
                wpay          = PAYLOAD_WIDTH'(item.payload);
                count_nxt     = count_r + CW'(1);
                ok_nxt        = 1'b1;
              end else if (!is_full) begin
                mem_ctl.rd_en = 1'b1;
                raddr         = last_idx;
                ptr_nxt       = last_idx;
                state_nxt     = S_DOWN;
              end
            end
            OP_REM_FIRST: begin
              if (count_r == CW'(1)) begin
                count_nxt = '0;
                ok_nxt    = 1'b1;
              end else if (!is_empty) begin
                mem_ctl.rd_en = 1'b1;
                raddr         = AW'(1);
                ptr_nxt       = AW'(1);
                found_nxt     = 1'b1;
                state_nxt     = S_UP;
              end
            end
            OP_REM_LAST: begin
              if (!is_empty) begin
                count_nxt = count_r - CW'(1);
                ok_nxt    = 1'b1;
              end
            end
            OP_REM_KEY, OP_FIND: begin
              if (!is_empty) begin
                mem_ctl.rd_en = 1'b1;
                raddr         = '0;
                ptr_nxt       = '0;
                state_nxt     = S_UP;
              end
            end
            OP_READ: begin
              if (CMPW'(item.position) < CMPW'(count_r)) begin
                mem_ctl.rd_en = 1'b1;
                raddr         = AW'(item.position);
                state_nxt     = S_READ;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_DOWN: begin
        mem_ctl.wr_en = 1'b1;
        waddr         = ptr_r + AW'(1);
        if ($signed(rkey) < key_r) begin
          count_nxt = count_r + CW'(1);
          ok_nxt    = 1'b1;
          state_nxt = S_RESP;
        end else begin
          wkey = rkey;
          wpay = rpay;
          if (ptr_r == '0) begin
            state_nxt = S_PLACE;
          end else begin
            mem_ctl.rd_en = 1'b1;
            raddr         = ptr_r - AW'(1);
            ptr_nxt       = ptr_r - AW'(1);
          end
        end
      end

      S_PLACE: begin
        mem_ctl.wr_en = 1'b1;
        waddr         = '0;
        count_nxt     = count_r + CW'(1);
        ok_nxt        = 1'b1;
        state_nxt     = S_RESP;
      end

      S_UP: begin
        if (op_r == OP_FIND) begin
          if (match) begin
            ok_nxt    = 1'b1;
            iout_nxt  = 6'(ptr_r);
            state_nxt = S_RESP;
          end else if (at_last) begin
            state_nxt = S_RESP;
          end else begin
            mem_ctl.rd_en = 1'b1;
            raddr         = ptr_r + AW'(1);
            ptr_nxt       = ptr_r + AW'(1);
          end
        end else begin
          if (found_r) begin
            mem_ctl.wr_en = 1'b1;
            waddr         = ptr_r - AW'(1);
            wkey          = rkey;
            wpay          = rpay;
          end
          found_nxt = found_r | match;
          if (at_last) begin
            if (found_r || match) begin
              count_nxt = count_r - CW'(1);
              ok_nxt    = 1'b1;
            end
            state_nxt = S_RESP;
          end else begin
            mem_ctl.rd_en = 1'b1;
            raddr         = ptr_r + AW'(1);
            ptr_nxt       = ptr_r + AW'(1);
          end
        end
      end

      S_READ: begin
        ok_nxt    = 1'b1;
        kout_nxt  = rkey;
        pout_nxt  = 32'(rpay);
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    key_r   <= key_nxt;
    pay_r   <= pay_nxt;
    ptr_r   <= ptr_nxt;
    found_r <= found_nxt;
    ok_r    <= ok_nxt;
    kout_r  <= kout_nxt;
    pout_r  <= pout_nxt;
    iout_r  <= iout_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);

  always_comb begin
    res             = '0;
    res.ok          = ok_r;
    res.key_out     = kout_r;
    res.payload_out = pout_r;
    res.index_out   = iout_r;
    res.count       = 7'(count_r);
    res.full_res    = is_full;
    res.empty_res   = is_empty;
  end

  `SK_ASSERT(a_count_in_range, clk, rst_n, count_r <= CW'(CAPACITY))
  `SK_ASSERT_NEVER(a_no_same_entry_rw, clk, rst_n, mem_ctl.wr_en && mem_ctl.rd_en && waddr == raddr)
  `SK_ASSERT(a_no_insert_when_full, clk, rst_n, state_r == S_DOWN |-> !is_full)
  `SK_ASSERT(a_count_moves_on_finish, clk, rst_n, state_r == S_IDLE |=> count_r == $past(count_r) || state_r == S_RESP)

endmodule

/* sv/sorted_key_table.sv */
// ----------------------------------------------------------------------------
// sorted_key_table
// Read by index and remove last need no walk; insert, remove and find walk the entries.
// Throughput: one item at a time; the single memory read port walks one entry
// per cycle, and a new item is taken only once its result has been accepted.
// Reset: synchronous, clears the entry count; the memory is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_key_table import sk_pkg::*; #(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW = $clog2(CAPACITY);

  logic                     start;
  logic                     idle;
  logic                     res_valid;
  logic                     res_ready;
  out_item_t                res;
  mem_ctl_t                 mem_ctl;
  logic [AW-1:0]            raddr;
  logic [AW-1:0]            waddr;
  logic [31:0]              wkey;
  logic [PAYLOAD_WIDTH-1:0] wpay;
  logic [31:0]              rkey;
  logic [PAYLOAD_WIDTH-1:0] rpay;

  logic      out_valid_r;
  out_item_t out_data_r;

  assign in_ready  = idle;
  assign start     = in_valid && idle;
  assign res_ready = !out_valid_r || out_ready;

  sk_ctrl #(
    .CAPACITY      (CAPACITY),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .item      (in_data),
    .idle      (idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_ctl   (mem_ctl),
    .raddr     (raddr),
    .waddr     (waddr),
    .wkey      (wkey),
    .wpay      (wpay),
    .rkey      (rkey),
    .rpay      (rpay)
  );

  sk_mem #(
    .CAPACITY      (CAPACITY),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .raddr (raddr),
    .waddr (waddr),
    .wkey  (wkey),
    .wpay  (wpay),
    .rkey  (rkey),
    .rpay  (rpay)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
